### design/huffman_table_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the port-level checker of the Huffman decoder.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_DECODER_DEFINES_SVH
`define HUFFMAN_TABLE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("huffman_table_decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("huffman_table_decoder: next-cycle check failed");

`endif

### design/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Types, codes and helpers shared by the Huffman table decoder files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

    localparam int SYMBOLS_DEFAULT      = 256;
    localparam int MAX_CODE_LEN_DEFAULT = 32;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic [31:0] code;
        logic [5:0]  length;
        logic [31:0] count;
    } htd_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_READ,
        ST_CMP,
        ST_EMIT,
        ST_FLUSH
    } htd_state_t;

    function automatic logic [31:0] low_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len >= 6'd32) begin
            m = 32'hffff_ffff;
        end else begin
            m = (32'h1 << len) - 32'h1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### design/htd_table_ram.sv
// ----------------------------------------------------------------------------
// htd_table_ram
// Code table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htd_table_ram
    import htd_pkg::*;
#(
    parameter int SYMBOLS = SYMBOLS_DEFAULT,
    parameter int AW      = 8
) (
    input  wire logic       aclk,
    input  wire logic       wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire htd_entry_t wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output htd_entry_t      rd_data
);

    htd_entry_t mem [SYMBOLS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### design/huffman_table_decoder.sv
// ----------------------------------------------------------------------------
// huffman_table_decoder: a load transfer is written from the idle state; a decode byte is
// accepted there, then per bit a shift state is followed by a read and a compare state for
// each table entry scanned up to the first match, an emit state per result and a closing
// flush state, emit and flush waiting on a stalled receiver; the single table port sets this.
// Reset (synchronous, active low) clears entry valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_table_decoder
    import htd_pkg::*;
#(
    parameter int SYMBOLS      = SYMBOLS_DEFAULT,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_entry_symbol,
    input  wire logic [31:0] s_entry_code,
    input  wire logic [5:0]  s_entry_length,
    input  wire logic [31:0] s_entry_count,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_symbol,
    output logic [1:0]       m_kind,
    output logic             m_last
);

    // Table index width and the effective code length limit (the accumulator is 32 bits).
    localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam logic [5:0] LIMIT_LEN = 6'(LIMIT);

    htd_state_t state_reg, state_next;

    // One valid bit per table entry; an entry that is not valid reads as absent.
    logic [SYMBOLS-1:0] valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  bit_idx_reg, bit_idx_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  len_reg, len_next;
    logic        stopped_reg, stopped_next;
    logic [AW-1:0] j_reg, j_next;

    // The newest result is held back in a pending slot so that its last flag is known
    // when it leaves: either another result follows or the byte ends.
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_symbol_reg, pend_symbol_next;
    logic [1:0]  pend_kind_reg, pend_kind_next;
    logic [7:0]  res_symbol_reg, res_symbol_next;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic        res_stop_reg, res_stop_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_symbol_reg, m_symbol_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic        m_last_reg, m_last_next;

    logic        wr_en;
    logic [AW-1:0] wr_addr;
    htd_entry_t  wr_data;
    htd_entry_t  rd_data;

    logic        out_free;
    logic        emit_ok;
    logic        e_match;
    logic        last_entry;
    logic        load_ok;
    logic        bit_in;
    logic [31:0] len_mask;

    // The read address is the scan index; data for entry j is seen in the compare state.
    // The count write-back of an entry happens in the compare state, and the next read of
    // the table comes from a later read state, so no forwarding path is needed.
    htd_table_ram #(
        .SYMBOLS (SYMBOLS),
        .AW      (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (j_reg),
        .rd_data (rd_data)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign emit_ok    = !pend_valid_reg || out_free;
    assign last_entry = (j_reg == AW'(SYMBOLS - 1));
    assign load_ok    = ({1'b0, s_entry_symbol} < 9'(SYMBOLS));
    assign bit_in     = byte_reg[bit_idx_reg];
    assign len_mask   = low_mask(len_reg);

    // A present entry matches when its length equals the accumulated length, lies within
    // the limit, and its low code bits equal the accumulator.
    assign e_match = valid_reg[j_reg] && (rd_data.length == len_reg)
                     && (rd_data.length <= LIMIT_LEN)
                     && ((rd_data.code & len_mask) == (acc_reg & len_mask));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            acc_reg        <= '0;
            len_reg        <= '0;
            stopped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            acc_reg        <= acc_next;
            len_reg        <= len_next;
            stopped_reg    <= stopped_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg        <= byte_next;
        bit_idx_reg     <= bit_idx_next;
        j_reg           <= j_next;
        pend_symbol_reg <= pend_symbol_next;
        pend_kind_reg   <= pend_kind_next;
        res_symbol_reg  <= res_symbol_next;
        res_kind_reg    <= res_kind_next;
        res_stop_reg    <= res_stop_next;
        m_symbol_reg    <= m_symbol_next;
        m_kind_reg      <= m_kind_next;
        m_last_reg      <= m_last_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_operation == OP_DECODE) && !stopped_reg) begin
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (e_match) begin
                    state_next = ST_EMIT;
                end else if (!last_entry) begin
                    state_next = ST_READ;
                end else if (len_reg >= LIMIT_LEN) begin
                    state_next = ST_EMIT;
                end else if (bit_idx_reg == 3'd0) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_BIT;
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    if (res_stop_reg || (bit_idx_reg == 3'd0)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_BIT;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        s_ready          = 1'b0;
        valid_next       = valid_reg;
        byte_next        = byte_reg;
        bit_idx_next     = bit_idx_reg;
        acc_next         = acc_reg;
        len_next         = len_reg;
        stopped_next     = stopped_reg;
        j_next           = j_reg;
        pend_valid_next  = pend_valid_reg;
        pend_symbol_next = pend_symbol_reg;
        pend_kind_next   = pend_kind_reg;
        res_symbol_next  = res_symbol_reg;
        res_kind_next    = res_kind_reg;
        res_stop_next    = res_stop_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_symbol_next    = m_symbol_reg;
        m_kind_next      = m_kind_reg;
        m_last_next      = m_last_reg;
        wr_en            = 1'b0;
        wr_addr          = AW'(s_entry_symbol);
        wr_data.code     = s_entry_code;
        wr_data.length   = s_entry_length;
        wr_data.count    = s_entry_count;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == OP_LOAD) begin
                        if (load_ok) begin
                            wr_en = 1'b1;
                            valid_next[AW'(s_entry_symbol)] = 1'b1;
                        end
                    end else if (!stopped_reg) begin
                        byte_next    = s_data_byte;
                        bit_idx_next = 3'd7;
                    end
                end
            end
            ST_BIT: begin
                acc_next = {acc_reg[30:0], bit_in};
                len_next = len_reg + 6'd1;
                j_next   = '0;
            end
            ST_READ: begin
            end
            ST_CMP: begin
                if (e_match) begin
                    res_symbol_next = 8'(j_reg) ^ 8'h80;
                    if (rd_data.count != 32'd0) begin
                        res_kind_next  = KIND_SYMBOL;
                        res_stop_next  = 1'b0;
                        wr_en          = 1'b1;
                        wr_addr        = j_reg;
                        wr_data        = rd_data;
                        wr_data.count  = rd_data.count - 32'd1;
                        acc_next       = '0;
                        len_next       = '0;
                    end else begin
                        res_kind_next  = KIND_END;
                        res_stop_next  = 1'b1;
                        stopped_next   = 1'b1;
                    end
                end else if (!last_entry) begin
                    j_next = j_reg + AW'(1);
                end else if (len_reg >= LIMIT_LEN) begin
                    res_symbol_next = 8'd0;
                    res_kind_next   = KIND_ERROR;
                    res_stop_next   = 1'b1;
                    stopped_next    = 1'b1;
                    acc_next        = '0;
                    len_next        = '0;
                end else if (bit_idx_reg != 3'd0) begin
                    bit_idx_next = bit_idx_reg - 3'd1;
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    if (pend_valid_reg) begin
                        m_valid_next  = 1'b1;
                        m_symbol_next = pend_symbol_reg;
                        m_kind_next   = pend_kind_reg;
                        m_last_next   = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_symbol_next = res_symbol_reg;
                    pend_kind_next   = res_kind_reg;
                    if (!res_stop_reg && (bit_idx_reg != 3'd0)) begin
                        bit_idx_next = bit_idx_reg - 3'd1;
                    end
                end
            end
            ST_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    m_valid_next    = 1'b1;
                    m_symbol_next   = pend_symbol_reg;
                    m_kind_next     = pend_kind_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_kind   = m_kind_reg;
    assign m_last   = m_last_reg;

endmodule

`default_nettype wire

### design/htd_checker.sv
// ----------------------------------------------------------------------------
// htd_checker
// Port-level checks for the Huffman table decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_table_decoder_defines.svh"

module htd_checker
    import htd_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_symbol,
    input wire logic [1:0] m_kind,
    input wire logic       m_last
);

    // A stalled result stays offered.
    `HTD_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)

    // End and error results stop decoding, so they always close their byte.
    `HTD_ASSERT_IMP(a_stop_is_last, aclk, aresetn, m_valid && (m_kind != KIND_SYMBOL), m_last)

    // An error result carries symbol zero.
    `HTD_ASSERT_IMP(a_error_symbol, aclk, aresetn, m_valid && (m_kind == KIND_ERROR), m_symbol == 8'd0)

    // After a stop result is taken, nothing but stillness follows on the next cycle.
    `HTD_ASSERT_NXT(a_stop_quiet, aclk, aresetn, m_valid && m_ready && (m_kind != KIND_SYMBOL), !m_valid)

endmodule

bind huffman_table_decoder htd_checker u_htd_checker (.*);

`default_nettype wire

### tb/sv/tb_huffman_table_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman table decoder testbench
// Loads code tables, mostly of complete fixed-length codes, streams packed bytes
// through the decoder and compares every decoded symbol, end marker and
// error marker against a cycle-free table model kept in this file.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_huffman_table_decoder;
    import htd_pkg::*;

    localparam int IDLE_LIMIT = 60000;  // cycles without any transfer
    localparam int DRAIN_WAIT = 5000;   // a full byte with a complete table scan per bit

    typedef struct {
        logic [7:0] symbol;
        logic [1:0] kind;
        logic       last;
    } decoded_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = OP_LOAD;
    logic [7:0] s_entry_symbol = '0;
    logic [31:0] s_entry_code = '0;
    logic [5:0] s_entry_length = '0;
    logic [31:0] s_entry_count = '0;
    logic [7:0] s_data_byte = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_symbol;
    logic [1:0] m_kind;
    logic m_last;

    huffman_table_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_entry_symbol(s_entry_symbol),
        .s_entry_code(s_entry_code), .s_entry_length(s_entry_length),
        .s_entry_count(s_entry_count), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_symbol(m_symbol), .m_kind(m_kind), .m_last(m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shadow copy of the decoder state.
    logic [31:0] tbl_code [256];
    logic [5:0]  tbl_len [256];
    logic [31:0] tbl_count [256];
    logic [31:0] acc_bits = '0;
    logic [5:0]  acc_len = '0;
    logic        halted = 1'b0;

    decoded_t expected_symbols[$];
    int mismatch_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    bit no_idle = 1'b0;      // when set, neither side inserts gaps
    bit hold_request = 1'b0; // asks the receiver for one long hold-off
    bit used_index [256];    // indices present in the current table
    int cur_code_len = 1;

    function automatic logic [31:0] len_mask(input logic [5:0] len);
        if (len >= 6'd32) begin
            return 32'hffff_ffff;
        end
        return (32'h1 << len) - 32'h1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Walk one byte through the shadow table, MSB first, and queue what it yields.
    task automatic predict_decode(input logic [7:0] db);
        decoded_t produced[$];
        decoded_t r;
        int hit;
        logic [31:0] cur;
        if (halted) begin
            return;
        end
        for (int b = 7; b >= 0 && !halted; b--) begin
            acc_len = acc_len + 6'd1;
            acc_bits = {acc_bits[30:0], db[b]};
            cur = acc_bits & len_mask(acc_len);
            hit = -1;
            for (int j = 0; j < 256; j++) begin
                if (tbl_len[j] != 0 && tbl_len[j] == acc_len && tbl_len[j] <= 6'd32 &&
                    (tbl_code[j] & len_mask(tbl_len[j])) == cur) begin
                    hit = j;
                    break;
                end
            end
            if (hit >= 0) begin
                r.symbol = hit[7:0] ^ 8'h80;
                r.last = 1'b0;
                if (tbl_count[hit] != 0) begin
                    r.kind = KIND_SYMBOL;
                    tbl_count[hit] = tbl_count[hit] - 32'd1;
                    acc_bits = '0;
                    acc_len = '0;
                end else begin
                    r.kind = KIND_END;
                    halted = 1'b1;
                end
                produced.push_back(r);
            end else if (acc_len >= 6'd32) begin
                r.symbol = 8'h00;
                r.kind = KIND_ERROR;
                r.last = 1'b0;
                produced.push_back(r);
                acc_bits = '0;
                acc_len = '0;
                halted = 1'b1;
            end
        end
        if (produced.size() > 0) begin
            produced[produced.size() - 1].last = 1'b1;
        end
        foreach (produced[k]) begin
            expected_symbols.push_back(produced[k]);
        end
    endtask

    // Offer one item, wait for its transfer, then update the shadow state.
    task automatic send_item(input logic op, input logic [7:0] idx, input logic [31:0] code,
                             input logic [5:0] len, input logic [31:0] cnt,
                             input logic [7:0] db);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_operation = op;
        s_entry_symbol = idx;
        s_entry_code = code;
        s_entry_length = len;
        s_entry_count = cnt;
        s_data_byte = db;
        // s_ready is read before the edge's register updates land.
        do begin
            @(posedge aclk);
        end while (!s_ready);
        items_sent++;
        if (op == OP_LOAD) begin
            tbl_code[idx] = code;
            tbl_len[idx] = len;
            tbl_count[idx] = cnt;
        end else begin
            predict_decode(db);
        end
    endtask

    task automatic load_entry(input logic [7:0] idx, input logic [31:0] code,
                              input logic [5:0] len, input logic [31:0] cnt);
        send_item(OP_LOAD, idx, code, len, cnt, 8'($urandom));
        used_index[idx] = (len != 0);
    endtask

    task automatic decode_byte(input logic [7:0] db);
        send_item(OP_DECODE, 8'($urandom), $urandom, 6'($urandom), $urandom, db);
    endtask

    function automatic logic [31:0] big_count();
        logic [31:0] c;
        c = $urandom;
        return (c < 32'd256) ? c + 32'd256 : c;
    endfunction

    // Mark every present entry absent again, with random code and count bits.
    task automatic clear_table();
        for (int j = 0; j < 256; j++) begin
            if (used_index[j]) begin
                load_entry(j[7:0], $urandom, 6'd0, $urandom);
            end
        end
    endtask

    // Loads a complete code of the given length on random indices, so every bit
    // pattern decodes and the accumulator never runs past the code length.
    task automatic load_complete_code(input int len);
        int idx;
        bit taken [256];
        logic [31:0] c;
        for (int j = 0; j < 256; j++) begin
            taken[j] = 1'b0;
        end
        for (int p = 0; p < (1 << len); p++) begin
            do begin
                idx = $urandom_range(0, 255);
            end while (taken[idx]);
            taken[idx] = 1'b1;
            c = ($urandom << len) | p;
            load_entry(idx[7:0], c, len[5:0], big_count());
        end
        // Sometimes a second entry shares a code; the lower index has to win.
        if ($urandom_range(0, 1) == 1) begin
            do begin
                idx = $urandom_range(0, 255);
            end while (taken[idx]);
            load_entry(idx[7:0], $urandom_range(0, (1 << len) - 1), len[5:0], big_count());
        end
        cur_code_len = len;
    endtask

    // Extremes: indices 0 and 255, all-zero and all-one bytes, overlong and
    // absent entries, a full-scale count and a shared code.
    task automatic test_directed();
        load_entry(8'd0, 32'hffff_fffe, 6'd1, 32'hffff_ffff);
        load_entry(8'd255, 32'h0000_0001, 6'd1, 32'd20);
        load_entry(8'd7, 32'h0000_0000, 6'd1, 32'd5);        // loses to index 0
        load_entry(8'd100, 32'hffff_ffff, 6'd63, 32'd1);     // longer than the limit
        load_entry(8'd101, 32'h0000_0000, 6'd33, 32'd1);     // longer than the limit
        load_entry(8'd102, 32'hffff_ffff, 6'd32, 32'd1);     // never reached here
        load_entry(8'd103, 32'h0000_0001, 6'd0, 32'd9);      // absent
        decode_byte(8'h00);
        decode_byte(8'hff);
        decode_byte(8'ha5);
        decode_byte(8'h5a);
        clear_table();
        cur_code_len = 1;
    endtask

    // Phases of random complete codes, each followed by random byte streams
    // whose length keeps the accumulator aligned at the phase boundary.
    task automatic test_random_streams();
        int nbytes;
        while (items_sent < 190) begin
            no_idle = ($urandom_range(0, 3) == 0);
            clear_table();
            load_complete_code($urandom_range(1, 4));
            nbytes = cur_code_len * $urandom_range(1, 4);
            repeat (nbytes) decode_byte(8'($urandom));
        end
        no_idle = 1'b0;
    endtask

    // The receiver stalls while bytes keep coming, so the decoder backs up.
    task automatic test_output_stall();
        hold_request = 1'b1;
        no_idle = 1'b1;
        repeat (cur_code_len * 3) decode_byte(8'($urandom));
        no_idle = 1'b0;
    endtask

    // Stops the stream, either on a zero-count code or on an overlong
    // accumulator, then checks that later bytes are ignored and loads still
    // pass. Only one of the two can happen per run, since reset is not repeated.
    task automatic test_stop();
        clear_table();
        if ($urandom_range(0, 1) == 1) begin
            load_entry(8'd200, 32'h0000_0002, 6'd2, 32'd1);
            load_entry(8'd3, 32'h0000_0000, 6'd2, 32'd0);
            decode_byte(8'b1000_1111);
        end else begin
            load_entry(8'd50, 32'h0000_0000, 6'd40, 32'd1);
            repeat (4) decode_byte(8'($urandom));
        end
        decode_byte(8'h00);
        load_entry(8'd1, 32'h0000_0000, 6'd1, 32'd1);
        decode_byte(8'hff);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = 3000;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_symbols.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result symbol %h kind %0d last %0d",
                         $realtime, m_symbol, m_kind, m_last);
            end else begin
                want = expected_symbols.pop_front();
                if (m_symbol !== want.symbol) begin
                    mismatch_count++;
                    $display("%0t: symbol expected %h actual %h", $realtime, want.symbol, m_symbol);
                end
                if (m_kind !== want.kind) begin
                    mismatch_count++;
                    $display("%0t: kind expected %0d actual %0d", $realtime, want.kind, m_kind);
                end
                if (m_last !== want.last) begin
                    mismatch_count++;
                    $display("%0t: last expected %0d actual %0d", $realtime, want.last, m_last);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        for (int j = 0; j < 256; j++) begin
            tbl_code[j] = '0;
            tbl_len[j] = '0;
            tbl_count[j] = '0;
            used_index[j] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_streams();
        test_output_stall();
        test_stop();

        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_symbols.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d items (loads and packed bytes), checked %0d decoded results,",
                 items_sent, results_checked);
        $display("including shared codes, an output stall and a stopped stream.");
        if (mismatch_count == 0 && expected_symbols.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
